FILE: design/qvr_pkg.sv
`default_nettype none
package qvr_pkg;

  // Vector component width and quaternion fraction bits.
  parameter int VECTOR_WIDTH   = 24;
  parameter int QUAT_FRAC_BITS = 15;

  // Quaternion component width (one sign/integer bit plus the fraction).
  localparam int QW = QUAT_FRAC_BITS + 1;
  // Product of a quaternion component and a vector component.
  localparam int P1W = QW + VECTOR_WIDTH;
  // Sum of three such products.
  localparam int TW = P1W + 2;
  // Product of an intermediate component and a quaternion component.
  localparam int P2W = TW + QW;
  // Sum of four such products plus the rounding constant.
  localparam int RW = P2W + 2;
  // Final scaling shift.
  localparam int SHIFT = 2 * QUAT_FRAC_BITS;
  // Width of the accumulator after the shift.
  localparam int SW = RW - SHIFT;

  typedef struct packed {
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] z;
    logic signed [QW-1:0] w;
  } quat_t;

  typedef struct packed {
    logic signed [VECTOR_WIDTH-1:0] x;
    logic signed [VECTOR_WIDTH-1:0] y;
    logic signed [VECTOR_WIDTH-1:0] z;
  } vec_t;

  // Intermediate product t = q * (v, 0).
  typedef struct packed {
    logic signed [TW-1:0] x;
    logic signed [TW-1:0] y;
    logic signed [TW-1:0] z;
    logic signed [TW-1:0] w;
  } tquat_t;

  // Unscaled vector part of t * conj(q), rounding constant already added.
  typedef struct packed {
    logic signed [RW-1:0] x;
    logic signed [RW-1:0] y;
    logic signed [RW-1:0] z;
  } acc_t;

  function automatic logic signed [P1W-1:0] mul_qv(input logic signed [QW-1:0] a,
                                                   input logic signed [VECTOR_WIDTH-1:0] b);
    mul_qv = P1W'(a) * P1W'(b);
  endfunction

  function automatic logic signed [P2W-1:0] mul_tq(input logic signed [TW-1:0] a,
                                                   input logic signed [QW-1:0] b);
    mul_tq = P2W'(a) * P2W'(b);
  endfunction

endpackage
`default_nettype wire

FILE: design/qvr_qv_prod.sv
`default_nettype none
module qvr_qv_prod import qvr_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire quat_t  q_in,
  input  wire vec_t   v_in,
  output logic        out_valid,
  input  wire logic   out_ready,
  output quat_t       q_out,
  output tquat_t      t_out
);

  logic                  v1_r, v2_r;
  logic                  rdy1, rdy2;
  logic signed [P1W-1:0] p_r [12];
  logic signed [P1W-1:0] p_nxt [12];
  quat_t                 q1_r, q2_r;
  tquat_t                t_r, t_nxt;

  assign rdy2     = !v2_r || out_ready;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // Products grouped by the component of t that they feed.
  always_comb begin
    p_nxt[0]  = mul_qv(q_in.w, v_in.x);
    p_nxt[1]  = mul_qv(q_in.y, v_in.z);
    p_nxt[2]  = mul_qv(q_in.z, v_in.y);
    p_nxt[3]  = mul_qv(q_in.w, v_in.y);
    p_nxt[4]  = mul_qv(q_in.x, v_in.z);
    p_nxt[5]  = mul_qv(q_in.z, v_in.x);
    p_nxt[6]  = mul_qv(q_in.w, v_in.z);
    p_nxt[7]  = mul_qv(q_in.x, v_in.y);
    p_nxt[8]  = mul_qv(q_in.y, v_in.x);
    p_nxt[9]  = mul_qv(q_in.x, v_in.x);
    p_nxt[10] = mul_qv(q_in.y, v_in.y);
    p_nxt[11] = mul_qv(q_in.z, v_in.z);
  end

  always_comb begin
    t_nxt.x = TW'(p_r[0]) + TW'(p_r[1]) - TW'(p_r[2]);
    t_nxt.y = TW'(p_r[3]) - TW'(p_r[4]) + TW'(p_r[5]);
    t_nxt.z = TW'(p_r[6]) + TW'(p_r[7]) - TW'(p_r[8]);
    t_nxt.w = -TW'(p_r[9]) - TW'(p_r[10]) - TW'(p_r[11]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      p_r  <= p_nxt;
      q1_r <= q_in;
    end
    if (rdy2 && v1_r) begin
      t_r  <= t_nxt;
      q2_r <= q1_r;
    end
  end

  assign out_valid = v2_r;
  assign q_out     = q2_r;
  assign t_out     = t_r;

endmodule
`default_nettype wire

FILE: design/qvr_tq_prod.sv
`default_nettype none
module qvr_tq_prod import qvr_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire quat_t  q_in,
  input  wire tquat_t t_in,
  output logic        out_valid,
  input  wire logic   out_ready,
  output acc_t        acc_out
);

  localparam logic signed [RW-1:0] HALF = RW'(1) <<< (SHIFT - 1);

  logic                  v1_r, v2_r;
  logic                  rdy1, rdy2;
  logic signed [P2W-1:0] p_r [12];
  logic signed [P2W-1:0] p_nxt [12];
  acc_t                  acc_r, acc_nxt;

  assign rdy2     = !v2_r || out_ready;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // Vector part of t * conj(q), four products per component.
  always_comb begin
    p_nxt[0]  = mul_tq(t_in.w, q_in.x);
    p_nxt[1]  = mul_tq(t_in.x, q_in.w);
    p_nxt[2]  = mul_tq(t_in.y, q_in.z);
    p_nxt[3]  = mul_tq(t_in.z, q_in.y);
    p_nxt[4]  = mul_tq(t_in.w, q_in.y);
    p_nxt[5]  = mul_tq(t_in.x, q_in.z);
    p_nxt[6]  = mul_tq(t_in.y, q_in.w);
    p_nxt[7]  = mul_tq(t_in.z, q_in.x);
    p_nxt[8]  = mul_tq(t_in.w, q_in.z);
    p_nxt[9]  = mul_tq(t_in.x, q_in.y);
    p_nxt[10] = mul_tq(t_in.y, q_in.x);
    p_nxt[11] = mul_tq(t_in.z, q_in.w);
  end

  always_comb begin
    acc_nxt.x = HALF - RW'(p_r[0]) + RW'(p_r[1]) - RW'(p_r[2]) + RW'(p_r[3]);
    acc_nxt.y = HALF - RW'(p_r[4]) + RW'(p_r[5]) + RW'(p_r[6]) - RW'(p_r[7]);
    acc_nxt.z = HALF - RW'(p_r[8]) - RW'(p_r[9]) + RW'(p_r[10]) + RW'(p_r[11]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) p_r <= p_nxt;
    if (rdy2 && v1_r) acc_r <= acc_nxt;
  end

  assign out_valid = v2_r;
  assign acc_out   = acc_r;

endmodule
`default_nettype wire

FILE: design/qvr_round_sat.sv
`default_nettype none
module qvr_round_sat import qvr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire acc_t acc_in,
  output logic      out_valid,
  input  wire logic out_ready,
  output vec_t      v_out,
  output logic      sat_out
);

  localparam logic signed [VECTOR_WIDTH-1:0] VMAX = {1'b0, {(VECTOR_WIDTH-1){1'b1}}};
  localparam logic signed [VECTOR_WIDTH-1:0] VMIN = {1'b1, {(VECTOR_WIDTH-1){1'b0}}};

  logic v_r;
  vec_t data_r, v_nxt;
  logic sat_r, sat_nxt;
  logic sx, sy, sz;

  // The value fits when every bit above the result's sign bit equals it.
  function automatic logic fits(input logic signed [RW-1:0] a);
    logic [SW-VECTOR_WIDTH:0] top;
    top  = a[RW-1:SHIFT+VECTOR_WIDTH-1];
    fits = (&top) || !(|top);
  endfunction

  function automatic logic signed [VECTOR_WIDTH-1:0] clip(input logic signed [RW-1:0] a);
    if (fits(a)) clip = a[SHIFT+VECTOR_WIDTH-1:SHIFT];
    else if (a[RW-1]) clip = VMIN;
    else clip = VMAX;
  endfunction

  always_comb begin
    sx        = !fits(acc_in.x);
    sy        = !fits(acc_in.y);
    sz        = !fits(acc_in.z);
    v_nxt.x   = clip(acc_in.x);
    v_nxt.y   = clip(acc_in.y);
    v_nxt.z   = clip(acc_in.z);
    sat_nxt   = sx || sy || sz;
  end

  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= v_nxt;
      sat_r  <= sat_nxt;
    end
  end

  assign out_valid = v_r;
  assign v_out     = data_r;
  assign sat_out   = sat_r;

endmodule
`default_nettype wire

FILE: design/quaternion_vector_rotate.sv
// Quaternion vector rotation, one rotation per item.
// Input channel: in_valid / in_stall with the quaternion (in_quat_x, _y, _z, _w,
// signed Q1.15) and the vector (in_vec_x, _y, _z, signed 24 bits). An item is
// taken at a rising edge where in_valid is high and in_stall is low.
// Result channel: out_valid / out_stall with out_x, out_y, out_z, the vector
// part of q*v*conj(q) shifted right by 30 with round-half-up, saturated to 24
// bits, and out_saturated, which is high when any component was clipped.
// The quaternion is used as given, so a non-unit quaternion scales the result.
// On the way from acceptance to out_valid, two stages form the
// twelve products of q and v and their sums, two more form the twelve products
// with conj(q) and their sums, and the last rounds and saturates.
// Throughput is one item per cycle; every stage holds one item and moves it
// on when the stage after it is empty or is moving too.
// When the receiver stalls, the held result stays steady and the stages behind
// it keep filling; in_stall rises only once all five stages hold items.
// The synchronous active-low reset empties the pipeline and no result is
// presented until a new item has gone through it.
`default_nettype none
module quaternion_vector_rotate import qvr_pkg::*; (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic signed [QW-1:0]           in_quat_x,
  input  wire logic signed [QW-1:0]           in_quat_y,
  input  wire logic signed [QW-1:0]           in_quat_z,
  input  wire logic signed [QW-1:0]           in_quat_w,
  input  wire logic signed [VECTOR_WIDTH-1:0] in_vec_x,
  input  wire logic signed [VECTOR_WIDTH-1:0] in_vec_y,
  input  wire logic signed [VECTOR_WIDTH-1:0] in_vec_z,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [VECTOR_WIDTH-1:0]      out_x,
  output logic signed [VECTOR_WIDTH-1:0]      out_y,
  output logic signed [VECTOR_WIDTH-1:0]      out_z,
  output logic                                out_saturated
);

  quat_t  q_in;
  vec_t   v_in;
  quat_t  q_s1;
  tquat_t t_s1;
  acc_t   acc_s2;
  vec_t   v_res;
  logic   in_ready;
  logic   s1_valid, s1_ready;
  logic   s2_valid, s2_ready;

  assign q_in = '{x: in_quat_x, y: in_quat_y, z: in_quat_z, w: in_quat_w};
  assign v_in = '{x: in_vec_x, y: in_vec_y, z: in_vec_z};

  // First half: t = q * (v, 0).
  qvr_qv_prod u_qv_prod (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .q_in      (q_in),
    .v_in      (v_in),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .q_out     (q_s1),
    .t_out     (t_s1)
  );

  // Second half: vector part of t * conj(q), with the rounding half added.
  qvr_tq_prod u_tq_prod (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .q_in      (q_s1),
    .t_in      (t_s1),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .acc_out   (acc_s2)
  );

  // Scaling, saturation and the output register.
  qvr_round_sat u_round_sat (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .acc_in    (acc_s2),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .v_out     (v_res),
    .sat_out   (out_saturated)
  );

  assign in_stall = !in_ready;
  assign out_x    = v_res.x;
  assign out_y    = v_res.y;
  assign out_z    = v_res.z;

  // The input only stalls when the pipeline is full behind a stalled result.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the pipeline could still advance");

  // A flagged result has at least one component sitting on a rail.
  a_sat_on_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_x == {1'b0, {(VECTOR_WIDTH-1){1'b1}}} || out_x == {1'b1, {(VECTOR_WIDTH-1){1'b0}}} ||
       out_y == {1'b0, {(VECTOR_WIDTH-1){1'b1}}} || out_y == {1'b1, {(VECTOR_WIDTH-1){1'b0}}} ||
       out_z == {1'b0, {(VECTOR_WIDTH-1){1'b1}}} || out_z == {1'b1, {(VECTOR_WIDTH-1){1'b0}}}))
    else $error("saturation flagged but no component is clipped");

  // The first half keeps a held item valid while the second half is not ready.
  a_s1_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && !s1_ready) |=> s1_valid)
    else $error("first half lost an item while stalled");

endmodule
`default_nettype wire
